// ===== rtl/pvd_pkg.sv =====
// pvd_pkg: shared types and constants for the prefix-length varint decoder
// no dependencies

package pvd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned LenWidth   = 4;

   // prefix byte that starts the raw little-endian form
   localparam logic [ByteWidth-1:0] PrefixRaw  = 8'hff;
   // prefix byte that starts the seven-byte big-endian form
   localparam logic [ByteWidth-1:0] PrefixLong = 8'hfe;

   localparam logic [LenWidth-1:0] RawFollow = 4'd8;
   localparam logic [LenWidth-1:0] RawLength = 4'd9;
   localparam logic [LenWidth-1:0] MaxLength = 4'd9;

   typedef struct packed {
      logic [ValueWidth-1:0] acc;
      logic [LenWidth-1:0]   remaining;
      logic [LenWidth-1:0]   total;
      logic                  little_endian;
   } dec_state_type;

   typedef struct packed {
      logic                  emit;
      logic [ValueWidth-1:0] value;
      logic [LenWidth-1:0]   length;
   } dec_result_type;

endpackage

// ===== rtl/pvd_step.sv =====
// pvd_step: combinational decode of one byte against the current decoder state
// depends on pvd_pkg

module pvd_step
   import pvd_pkg::*;
(
   input  dec_state_type        state_cur,
   input  logic [ByteWidth-1:0] byte_cur,
   output dec_state_type        state_nxt,
   output dec_result_type       result
);

   logic [ByteWidth-1:0]  payload;
   logic [LenWidth-1:0]   follow;
   logic [LenWidth-1:0]   rem_dec;
   logic [2:0]            pos;
   logic [LenWidth-1:0]   pos_wide;
   logic [ValueWidth-1:0] byte_wide;
   logic [ValueWidth-1:0] acc_merged;

   // leading-ones count of the prefix sets the follow count
   always_comb begin
      payload = '0;
      follow  = RawFollow;
      if (byte_cur < 8'h80) begin
         payload = byte_cur;
         follow  = 4'd0;
      end else if (byte_cur < 8'hc0) begin
         payload = byte_cur & 8'h3f;
         follow  = 4'd1;
      end else if (byte_cur < 8'he0) begin
         payload = byte_cur & 8'h1f;
         follow  = 4'd2;
      end else if (byte_cur < 8'hf0) begin
         payload = byte_cur & 8'h0f;
         follow  = 4'd3;
      end else if (byte_cur < 8'hf8) begin
         payload = byte_cur & 8'h07;
         follow  = 4'd4;
      end else if (byte_cur < 8'hfc) begin
         payload = byte_cur & 8'h03;
         follow  = 4'd5;
      end else if (byte_cur < PrefixLong) begin
         payload = byte_cur & 8'h01;
         follow  = 4'd6;
      end else if (byte_cur == PrefixLong) begin
         payload = '0;
         follow  = 4'd7;
      end
   end

   assign rem_dec   = state_cur.remaining - 4'd1;
   assign pos_wide  = RawFollow - state_cur.remaining;
   assign pos       = pos_wide[2:0];
   assign byte_wide = {{(ValueWidth-ByteWidth){1'b0}}, byte_cur};

   always_comb begin
      if (state_cur.little_endian) begin
         acc_merged = state_cur.acc | (byte_wide << {pos, 3'b000});
      end else begin
         acc_merged = {state_cur.acc[ValueWidth-ByteWidth-1:0], byte_cur};
      end
   end

   always_comb begin
      state_nxt    = state_cur;
      result.emit  = 1'b0;
      result.value = acc_merged;
      result.length = state_cur.total;
      if (state_cur.remaining == '0) begin
         if (follow == '0) begin
            // single-byte value goes straight out
            result.emit   = 1'b1;
            result.value  = byte_wide;
            result.length = 4'd1;
            state_nxt     = '0;
         end else begin
            state_nxt.acc           = {{(ValueWidth-ByteWidth){1'b0}}, payload};
            state_nxt.remaining     = follow;
            state_nxt.total         = follow + 4'd1;
            state_nxt.little_endian = (byte_cur == PrefixRaw);
         end
      end else if (rem_dec == '0) begin
         result.emit = 1'b1;
         state_nxt   = '0;
      end else begin
         state_nxt.acc       = acc_merged;
         state_nxt.remaining = rem_dec;
      end
   end

endmodule

// ===== rtl/prefix_varint_decoder.sv =====
// prefix_varint_decoder: top level, input register, decoder state and result register
// depends on pvd_pkg and pvd_step
//
//  channel | ports                                        | direction
//  req     | req_valid, req_ready, req_byte_in[7:0]       | in
//  rsp     | rsp_valid, rsp_ready, rsp_value[63:0],       | out
//          | rsp_encoded_length[3:0]                      |
//
// one byte beat per cycle sustained while rsp is not stalled; a result reaches rsp from the
// req beat of its last byte through the input register, then decode into the result register
// a value comes out on the beat of its last byte; other bytes only update state
// synchronous active-high reset clears the decoder state and both valid flags
// a stalled rsp holds the input register, and req_ready drops once it is full

module prefix_varint_decoder
   import pvd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ByteWidth-1:0]  req_byte_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ValueWidth-1:0] rsp_value,
   output logic [LenWidth-1:0]   rsp_encoded_length
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff, in_byte_in;

   // decoder state
   dec_state_type state_ff, state_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0] out_value_ff, out_value_in;
   logic [LenWidth-1:0]   out_len_ff, out_len_in;

   dec_state_type  state_nxt;
   dec_result_type step_res;
   logic           advance;

   pvd_step u_step (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .state_nxt (state_nxt),
      .result    (step_res)
   );

   // the held byte moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_byte_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_len_in   = out_len_ff;
      if (advance) begin
         state_in = state_nxt;
         if (step_res.emit) begin
            out_valid_in = 1'b1;
            out_value_in = step_res.value;
            out_len_in   = step_res.length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_value_ff <= out_value_in;
      out_len_ff   <= out_len_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_encoded_length = out_len_ff;

   // follow count never exceeds the raw form's eight bytes
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.remaining <= RawFollow)
      else $error("bytes remaining out of range");

   // raw little-endian form always carries length nine
   a_raw_len: assert property (@(posedge clock) disable iff (reset)
      state_ff.little_endian |-> (state_ff.total == RawLength))
      else $error("raw form with wrong total length");

   // a delivered length is always between one and nine
   a_out_len: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_len_ff != '0 && out_len_ff <= MaxLength))
      else $error("encoded length out of range");

   // a new result only appears when a byte left the input register
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff || rsp_ready) && !advance |=> !out_valid_ff)
      else $error("result appeared without a decoded byte");

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for the prefix-length varint decoder
// depends on pvd_pkg and prefix_varint_decoder; predicts each decoded value
// from the byte beats it accepts and checks every rsp beat against it
`timescale 1ns / 1ps

module testbench
   import pvd_pkg::*;
();

   // one decoded value as the rsp channel should carry it
   typedef struct {
      logic [ValueWidth-1:0] value;
      logic [LenWidth-1:0]   length;
   } decoded_type;

   // length of the long receiver hold-off, in cycles
   localparam int unsigned HoldLength = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ByteWidth-1:0]  req_byte_in;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ValueWidth-1:0] rsp_value;
   logic [LenWidth-1:0]   rsp_encoded_length;

   // decoded values still owed by the block, oldest first
   decoded_type pending_values[$];
   int unsigned error_count = 0;

   // idling knobs, in percent of cycles
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   // long receiver hold-off: a toggle asks for one, the receiver counts it down
   logic        hold_req = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_cycles = 0;

   // decoder state as the bench sees it
   logic [ValueWidth-1:0] model_acc;
   logic [LenWidth-1:0]   model_left;
   logic [LenWidth-1:0]   model_total;
   logic                  model_raw;

   prefix_varint_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value          (rsp_value),
      .rsp_encoded_length (rsp_encoded_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // advance the decoder state by one accepted byte, queue a value when one completes
   function automatic void decode_byte(input logic [ByteWidth-1:0] b);
      int unsigned ones;
      int unsigned pos;
      logic [ByteWidth-1:0] payload;
      decoded_type done;
      if (model_left == 0) begin
         // prefix byte: leading ones give the number of bytes that follow
         ones = 0;
         while (ones < 8 && b[7 - ones]) ones++;
         model_raw = (b == PrefixRaw);
         if (ones == 0) begin
            // single-byte value comes out at once
            done.value  = ValueWidth'(b);
            done.length = LenWidth'(1);
            pending_values.push_back(done);
            model_acc   = '0;
            model_total = '0;
         end else begin
            // payload mask is empty for both the long and the raw prefix
            payload     = b & (8'hff >> (ones + 1));
            model_acc   = ValueWidth'(payload);
            model_left  = LenWidth'(ones);
            model_total = LenWidth'(ones + 1);
         end
      end else begin
         if (model_raw) begin
            // raw form: k-th byte after the prefix, counting from zero, lands in byte lane k
            pos = 8 - model_left;
            model_acc = model_acc | (ValueWidth'(b) << (8 * pos));
         end else begin
            model_acc = {model_acc[ValueWidth-ByteWidth-1:0], b};
         end
         model_left = model_left - 1'b1;
         if (model_left == 0) begin
            done.value  = model_acc;
            done.length = model_total;
            pending_values.push_back(done);
            model_acc   = '0;
            model_total = '0;
            model_raw   = 1'b0;
         end
      end
   endfunction

   // offer one byte beat, with random idle cycles ahead of it
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      decode_byte(b);
   endtask

   // encode bits as a value of len bytes; short forms keep only their payload bits
   task automatic send_value(input int unsigned len, input logic [ValueWidth-1:0] bits);
      int unsigned f;
      logic [ByteWidth-1:0] lead;
      if (len == MaxLength) begin
         send_byte(PrefixRaw);
         for (int k = 0; k < 8; k++) send_byte(bits[8*k +: 8]);
      end else begin
         f    = len - 1;
         lead = 8'hff << (8 - f);
         send_byte(lead | (bits[8*f +: 8] & (8'hff >> (f + 1))));
         for (int k = int'(f) - 1; k >= 0; k--) send_byte(bits[8*k +: 8]);
      end
   endtask

   // drop valid and hold off until every owed value has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
   endtask

   task automatic set_idling(input int unsigned sender, input int unsigned receiver);
      sender_idle_pct = sender;
      stall_pct       = receiver;
   endtask

   // single-byte values at both ends of their range
   task automatic test_single_byte();
      send_value(1, '0);
      send_value(1, 64'h7f);
      drain();
   endtask

   // raw little-endian form, distinct bytes so lane order shows
   task automatic test_raw_little_endian();
      send_value(MaxLength, 64'h0807_0605_0403_0201);
      drain();
   endtask

   // shortest multi-byte form with zeros, seven-byte form with all ones
   task automatic test_big_endian_forms();
      send_value(2, '0);
      send_value(MaxLength - 1, '1);
      drain();
   endtask

   // mostly well-formed values of random length and content, some stray bytes
   task automatic test_random_stream(input int unsigned n_bytes);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      logic [ValueWidth-1:0] bits;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(9, 0) == 0) begin
            send_byte(ByteWidth'($urandom_range(255, 0)));
            sent++;
         end else begin
            len  = $urandom_range(MaxLength, 1);
            pick = $urandom_range(7, 0);
            // now and then an all-zeros or all-ones value
            if (pick == 0) bits = '0;
            else if (pick == 1) bits = '1;
            else bits = {$urandom, $urandom};
            send_value(len, bits);
            sent += len;
         end
      end
      drain();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      hold_req = ~hold_req;
      test_random_stream(100);
   endtask

   // value left unfinished at the end of the stream must never come out
   task automatic test_partial_tail();
      while (model_left != 0) send_byte(ByteWidth'($urandom_range(255, 0)));
      send_byte(8'hf5);
      send_byte(ByteWidth'($urandom_range(255, 0)));
      send_byte(ByteWidth'($urandom_range(255, 0)));
      drain();
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_req != hold_seen) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= HoldLength - 1;
         hold_seen   <= hold_req;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // compare each rsp beat with the oldest owed value
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            error_count++;
            $display("%0t: unexpected rsp beat, expected none, got value %h length %0d",
                     $time, rsp_value, rsp_encoded_length);
         end else begin
            want = pending_values.pop_front();
            if (rsp_value !== want.value) begin
               error_count++;
               $display("%0t: value mismatch, expected %h, got %h",
                        $time, want.value, rsp_value);
            end
            if (rsp_encoded_length !== want.length) begin
               error_count++;
               $display("%0t: encoded_length mismatch, expected %0d, got %0d",
                        $time, want.length, rsp_encoded_length);
            end
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_byte_in = '0;
      model_acc   = '0;
      model_left  = '0;
      model_total = '0;
      model_raw   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed cases, no idling
      test_single_byte();
      test_raw_little_endian();
      test_big_endian_forms();

      // random stream under each idling pattern
      set_idling(0, 0);
      test_random_stream(260);
      set_idling(75, 0);
      test_random_stream(180);
      set_idling(0, 75);
      test_random_stream(180);
      set_idling(7, 7);
      test_random_stream(180);

      // fill the block up behind a long rsp stall
      set_idling(0, 0);
      test_backpressure();

      // unfinished value at the end, then watch for stray beats
      test_partial_tail();
      repeat (16) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
